// File: design/csdd_pkg.sv
// Shared types and constants for the chi-squared descriptor distance block.
package csdd_pkg;

   localparam int VALUE_W             = 8;
   localparam int DSQ_W               = 2 * VALUE_W;
   localparam int PSUM_W              = VALUE_W + 1;
   localparam int DIST_W              = 15;
   localparam int THR_W               = 16;
   localparam int FRACTION_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF     = 4;
   localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;
   localparam logic [THR_W-1:0]  THR_RESET = 16'hFFFF;

   typedef struct packed {
      logic [DSQ_W-1:0]  diff_sq;
      logic [PSUM_W-1:0] pair_sum;
      logic              zero_pair;
      logic              last;
   } elem_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic stopped;
      logic accum_zero;
      logic emit;
   } back_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_ACC    = 4'b0100,
      ST_EMIT   = 4'b1000
   } back_state_type;

endpackage

// File: design/csdd_front.sv
// Front end: takes element pairs and forms squared difference and pair sum.
module csdd_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [csdd_pkg::VALUE_W-1:0]  req_first_value,
   input  logic [csdd_pkg::VALUE_W-1:0]  req_second_value,
   input  logic                          req_last_element,
   input  csdd_pkg::queue_stat_type      q_stat,
   output logic                          q_push,
   output csdd_pkg::elem_type            q_wr_elem
);
   import csdd_pkg::*;

   logic [VALUE_W-1:0] diff;

   always_comb begin
      if (req_first_value >= req_second_value) begin
         diff = req_first_value - req_second_value;
      end else begin
         diff = req_second_value - req_first_value;
      end
   end

   assign req_ready           = !q_stat.full;
   assign q_push              = req_valid && !q_stat.full;
   assign q_wr_elem.diff_sq   = DSQ_W'(diff) * DSQ_W'(diff);
   assign q_wr_elem.pair_sum  = PSUM_W'(req_first_value) + PSUM_W'(req_second_value);
   assign q_wr_elem.zero_pair = (req_first_value == '0) && (req_second_value == '0);
   assign q_wr_elem.last      = req_last_element;

endmodule

// File: design/csdd_queue.sv
// Short FIFO of classified element beats between front and back.
module csdd_queue #(
   parameter int DEPTH = csdd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  csdd_pkg::elem_type        wr_elem,
   input  logic                      pop,
   output csdd_pkg::elem_type        rd_elem,
   output csdd_pkg::queue_stat_type  stat
);
   import csdd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   elem_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_elem    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_elem;
      end
   end

endmodule

// File: design/csdd_back.sv
// Back end: restoring divider, saturating accumulator, stop logic, result register.
module csdd_back #(
   parameter int FRACTION_BITS = csdd_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csdd_pkg::elem_type            q_elem,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  logic [csdd_pkg::THR_W-1:0]    stop_threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [csdd_pkg::DIST_W-1:0]   rsp_distance,
   output csdd_pkg::back_stat_type       stat
);
   import csdd_pkg::*;

   localparam int QW    = VALUE_W + FRACTION_BITS;
   localparam int ACC_W = DIST_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(QW);
   localparam logic [ACC_W:0] SUM_CAP = {1'b0, DIST_MAX, {FRACTION_BITS{1'b0}}};
   localparam logic [ACC_W:0] HALF    = (ACC_W + 1)'(1) << (FRACTION_BITS - 1);

   back_state_type      state_ff, state_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                stopped_ff, stopped_in;
   logic                last_ff, last_in;
   logic [PSUM_W-1:0]   div_ff, div_in;
   logic [PSUM_W-1:0]   rem_ff, rem_in;
   logic [QW-1:0]       nsh_ff, nsh_in;
   logic [QW-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic                stop_now;
   logic [PSUM_W:0]     rem_shift;
   logic [PSUM_W:0]     rem_diff;
   logic                q_bit;
   logic [ACC_W:0]      acc_sum;
   logic [ACC_W:0]      acc_rnd;
   logic                out_free;
   logic                emit_now;

   assign stop_now  = stopped_ff ||
                      ({1'b0, acc_ff} > {stop_threshold, {FRACTION_BITS{1'b0}}});
   assign rem_shift = {rem_ff, nsh_ff[QW-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};
   assign q_bit     = (rem_shift >= {1'b0, div_ff});
   assign acc_sum   = {1'b0, acc_ff} + (ACC_W + 1)'(quo_ff);
   assign acc_rnd   = {1'b0, acc_ff} + HALF;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      stopped_in   = stopped_ff;
      last_in      = last_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      nsh_in       = nsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      q_pop        = 1'b0;
      emit_now     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               stopped_in = stop_now;
               last_in    = q_elem.last;
               div_in     = q_elem.pair_sum;
               rem_in     = {1'b0, q_elem.diff_sq[DSQ_W-1:VALUE_W]};
               nsh_in     = {q_elem.diff_sq[VALUE_W-1:0], {FRACTION_BITS{1'b0}}};
               quo_in     = '0;
               cnt_in     = CNT_W'(QW - 1);
               if (!stop_now && !q_elem.zero_pair) begin
                  state_in = ST_DIVIDE;
               end else if (q_elem.last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in = q_bit ? rem_diff[PSUM_W-1:0] : rem_shift[PSUM_W-1:0];
            nsh_in = {nsh_ff[QW-2:0], 1'b0};
            quo_in = {quo_ff[QW-2:0], q_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in   = (acc_sum > SUM_CAP) ? SUM_CAP[ACC_W-1:0] : acc_sum[ACC_W-1:0];
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = acc_rnd[FRACTION_BITS +: DIST_W];
               acc_in       = '0;
               stopped_in   = 1'b0;
               emit_now     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      nsh_ff      <= nsh_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign stat         = {stopped_ff, (acc_ff == '0), emit_now};

endmodule

// File: design/chi_squared_descriptor_distance.sv
// Top level of the chi-squared descriptor distance block.
// Streams two byte descriptors one element pair per beat and returns one rounded
// distance beat for each beat marked last_element. The front takes a beat every
// cycle, while the queue is not full, into a four-entry queue (the default depth);
// the back passes over a zero pair or an element after the stop threshold was
// passed, and runs any other element through the restoring divider, which yields
// one quotient bit per cycle, and then the saturating accumulator. A last beat
// loads the result register once the output is free. Threshold writes are taken
// every cycle and act from the next element the back picks up.
module chi_squared_descriptor_distance #(
   parameter int FRACTION_BITS = csdd_pkg::FRACTION_BITS_DEF,
   parameter int QUEUE_DEPTH   = csdd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [csdd_pkg::VALUE_W-1:0]  req_first_value,
   input  logic [csdd_pkg::VALUE_W-1:0]  req_second_value,
   input  logic                          req_last_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [csdd_pkg::DIST_W-1:0]   rsp_distance,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [csdd_pkg::THR_W-1:0]    csr_stop_threshold
);
   import csdd_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;
   logic             q_push, q_pop;
   elem_type         q_wr_elem, q_rd_elem;
   queue_stat_type   q_stat;
   back_stat_type    b_stat;

   assign csr_ready = 1'b1;
   assign thr_in    = (csr_valid && csr_ready) ? csr_stop_threshold : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   csdd_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .req_last_element (req_last_element),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_wr_elem        (q_wr_elem)
   );

   csdd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_elem (q_wr_elem),
      .pop     (q_pop),
      .rd_elem (q_rd_elem),
      .stat    (q_stat)
   );

   csdd_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_elem         (q_rd_elem),
      .q_valid        (!q_stat.empty),
      .q_pop          (q_pop),
      .stop_threshold (thr_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_distance   (rsp_distance),
      .stat           (b_stat)
   );

`ifndef SYNTHESIS
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty at once");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      b_stat.emit |=> (b_stat.accum_zero && !b_stat.stopped))
      else $error("accumulator not cleared after result beat");

   a_stop_nonzero: assert property (@(posedge clock) disable iff (reset)
      b_stat.stopped |-> !b_stat.accum_zero)
      else $error("stopped with empty accumulator");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      b_stat.emit |=> rsp_valid)
      else $error("result beat not presented after emit");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the chi-squared descriptor distance block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csdd_pkg::*;

   localparam int        FB             = FRACTION_BITS_DEF;
   localparam bit [31:0] SUM_CAP        = 32'(DIST_MAX) << FB;
   localparam int        ITEM_TARGET    = 1950;
   localparam int        CALM_ITEMS     = 300;
   localparam int        SETTLE_CYCLES  = 250;
   localparam int        HOLD_CYCLES    = 400;
   localparam int        WATCHDOG_LIMIT = 5000;

   class chi_distance_tracker;
      bit [31:0]       running_sum;
      bit              stopped;
      bit [THR_W-1:0]  threshold = THR_RESET;
      bit [DIST_W-1:0] pending_distances[$];
      int              errors;

      task report(string what);
         errors++;
         $display("tb: mismatch at %0t: %s", $time, what);
      endtask

      function void set_threshold(bit [THR_W-1:0] value);
         threshold = value;
      endfunction

      function void take_element(bit [VALUE_W-1:0] a, bit [VALUE_W-1:0] b, bit last);
         bit [VALUE_W-1:0] diff;
         bit [DSQ_W-1:0]   diff_sq;
         bit [PSUM_W-1:0]  pair_sum;
         bit [31:0]        rounded;
         diff     = (a >= b) ? a - b : b - a;
         diff_sq  = DSQ_W'(diff) * DSQ_W'(diff);
         pair_sum = PSUM_W'(a) + PSUM_W'(b);
         if (!stopped && running_sum > (32'(threshold) << FB))
            stopped = 1'b1;
         if (!stopped && pair_sum != 0) begin
            running_sum += (32'(diff_sq) << FB) / 32'(pair_sum);
            if (running_sum > SUM_CAP)
               running_sum = SUM_CAP;
         end
         if (last) begin
            rounded = (running_sum + (32'd1 << (FB - 1))) >> FB;
            pending_distances = {pending_distances,
                                 (rounded > 32'(DIST_MAX)) ? DIST_MAX
                                                           : rounded[DIST_W-1:0]};
            running_sum = '0;
            stopped     = 1'b0;
         end
      endfunction

      task check_distance(logic [DIST_W-1:0] got);
         bit [DIST_W-1:0] want;
         if (pending_distances.size() == 0) begin
            report($sformatf("distance beat %0d with none expected", got));
            return;
         end
         want = pending_distances.pop_front();
         if (got !== want)
            report($sformatf("distance expected %0d got %0d", want, got));
      endtask
   endclass

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic [VALUE_W-1:0]  req_first_value    = '0;
   logic [VALUE_W-1:0]  req_second_value   = '0;
   logic                req_last_element   = 1'b0;
   logic                rsp_ready          = 1'b0;
   logic                csr_valid          = 1'b0;
   logic [THR_W-1:0]    csr_stop_threshold = '0;
   logic                req_ready;
   logic                rsp_valid;
   logic [DIST_W-1:0]   rsp_distance;
   logic                csr_ready;

   chi_distance_tracker tracker;
   int                  req_gap_odds   = 4;
   int                  rsp_stall_odds = 4;
   bit                  rsp_hold;
   int                  items_sent;
   int                  quiet_cycles;

   chi_squared_descriptor_distance dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .req_last_element   (req_last_element),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distance       (rsp_distance),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_stop_threshold (csr_stop_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.take_element(req_first_value, req_second_value, req_last_element);
         if (csr_valid && csr_ready)
            tracker.set_threshold(csr_stop_threshold);
         if (rsp_valid && rsp_ready)
            tracker.check_distance(rsp_distance);
         if ((req_valid && req_ready) || (csr_valid && csr_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else if (rsp_stall_odds != 0 && $urandom_range(0, rsp_stall_odds) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_pair(input bit [VALUE_W-1:0] a, input bit [VALUE_W-1:0] b,
                            input bit last);
      if (req_gap_odds != 0 && $urandom_range(0, req_gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_value  <= a;
      req_second_value <= b;
      req_last_element <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input bit [THR_W-1:0] value);
      csr_valid          <= 1'b1;
      csr_stop_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic bit [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return VALUE_W'($urandom_range(0, 3));
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic send_descriptor(input int length);
      bit [VALUE_W-1:0] a;
      bit [VALUE_W-1:0] b;
      for (int i = 0; i < length; i++) begin
         a = pick_value();
         b = pick_value();
         if ($urandom_range(0, 7) == 0) begin
            a = '0;
            b = '0;
         end
         send_pair(a, b, i == length - 1);
      end
   endtask

   initial begin
      int             phase;
      int             length;
      bit             calm;
      bit [THR_W-1:0] thr;
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair('0, '0, 1'b1);
      send_pair('1, '0, 1'b0);
      send_pair('0, '1, 1'b0);
      send_pair('1, '1, 1'b0);
      send_pair(8'd128, 8'd127, 1'b1);
      send_pair(8'd1, 8'd0, 1'b0);
      send_pair(8'd0, 8'd0, 1'b0);
      send_pair(8'd2, 8'd1, 1'b0);
      send_pair(8'd1, 8'd2, 1'b1);
      send_pair(8'd5, 8'd3, 1'b1);           // exactly one half, rounds up
      pause_until_drained();
      write_threshold('0);
      send_pair(8'd1, 8'd0, 1'b0);
      send_pair(8'd1, 8'd0, 1'b0);           // over threshold: ignored
      send_pair(8'd200, 8'd0, 1'b1);         // ignored, still emits
      pause_until_drained();
      write_threshold(16'd1);
      send_pair(8'd1, 8'd0, 1'b0);
      send_pair(8'd1, 8'd0, 1'b0);           // equal is not over
      send_pair(8'd1, 8'd0, 1'b1);
      pause_until_drained();
      write_threshold(THR_RESET);
      send_pair('1, '0, 1'b0);
      send_pair('1, '0, 1'b0);
      pause_until_drained();
      write_threshold(16'd100);              // lowered mid-descriptor
      send_pair('1, '0, 1'b0);
      send_pair(8'd10, 8'd0, 1'b1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         pause_until_drained();
         case (phase % 6)
            0:       thr = THR_RESET;
            1:       thr = '0;
            2:       thr = 16'd32767;
            3:       thr = THR_W'($urandom_range(0, 400));
            4:       thr = THR_W'($urandom);
            default: thr = THR_W'($urandom_range(1, 40));
         endcase
         write_threshold(thr);
         calm = items_sent >= ITEM_TARGET - CALM_ITEMS;
         req_gap_odds   = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
         rsp_stall_odds = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
         if (phase == 0) begin
            // enough extreme pairs to saturate the sum
            for (int i = 0; i < 140; i++) begin
               if ($urandom_range(0, 1))
                  send_pair('1, '0, i == 139);
               else
                  send_pair('0, '1, i == 139);
            end
         end
         if (phase == 1) begin
            rsp_hold = 1'b1;
            repeat (30) send_descriptor($urandom_range(1, 2));
         end
         repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 24) == 0)
               length = $urandom_range(100, 160);
            else
               length = $urandom_range(1, 24);
            send_descriptor(length);
         end
         // leave a descriptor open across the threshold write
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 5)) send_pair(pick_value(), pick_value(), 1'b0);
         phase++;
      end

      pause_until_drained();
      if (tracker.errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
